[rtl/bilateral_filter_7x7_core_assert.svh]
// Assertion macros for the bilateral filter RTL.
// Needs nothing else; included by files that check their own invariants.
`ifndef BILATERAL_FILTER_7X7_CORE_ASSERT_SVH
`define BILATERAL_FILTER_7X7_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BF7_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bf7 invariant violated");

// Condition that must hold in the cycle after a trigger.
`define BF7_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bf7 sequence violated");

`endif

[rtl/bf7_pkg.sv]
// Shared constants, types and weight tables of the 7x7 bilateral filter.
// No dependencies; the datapath, control and top-level files refer to it by scoped names.
`default_nettype none

package bf7_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int RADIUS       = 3;
   localparam int KW           = 2 * RADIUS + 1;
   localparam int TAPS         = KW * KW;
   localparam int LS_DEPTH     = KW * MAX_WIDTH;
   localparam int LS_ADDR_W    = $clog2(LS_DEPTH);
   localparam int TAP_W        = $clog2(KW);
   localparam int TAP_IDX_W    = $clog2(TAPS);

   localparam int PIXEL_W      = 8;
   localparam int COL_W        = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int LAG_W        = 13;
   localparam int WEIGHT_W     = 16;
   localparam int WT_W         = 2 * WEIGHT_W;
   localparam int DEN_W        = WT_W + TAP_IDX_W;
   localparam int NUM_W        = DEN_W + PIXEL_W;
   localparam int QUO_W        = PIXEL_W + 1;
   localparam int SHIFT_W      = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_TAPS,
      ST_FLUSH,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               accept;
      logic               start;
      logic               read;
      logic               issue;
      logic [TAP_W-1:0]   tap_i;
      logic [TAP_W-1:0]   tap_j;
      logic               latch_center;
      logic               div_load;
      logic               div_step;
      logic [SHIFT_W-1:0] div_shift;
      logic               rsp_load;
   } cmd_type;

   typedef struct packed {
      logic emit_now;
      logic pipe_busy;
      logic rsp_free;
   } status_type;

   typedef logic [WEIGHT_W-1:0] spatial_table_type [TAPS];
   typedef logic [WEIGHT_W-1:0] range_table_type [256];

   // unsigned 64-bit quotient by shift and subtract, for building the tables
   function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      int              n;
      q = 0;
      r = 0;
      for (n = 63; n >= 0; n--) begin
         r = {r[62:0], a[n]};
         if (r >= b) begin
            r    = r - b;
            q[n] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(num/den) in Q32 from a truncated Taylor sum
   function automatic longint unsigned exp_q32(longint unsigned num, longint unsigned den);
      longint unsigned sum;
      longint unsigned term;
      longint unsigned k;
      logic            done;
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      done = 1'b0;
      for (k = 1; k < 80; k++) begin
         if (!done) begin
            term = udiv64(term * num, den * k);
            if (term == 0) begin
               done = 1'b1;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic spatial_table_type build_spatial();
      spatial_table_type tbl;
      longint unsigned   g [TAPS];
      longint unsigned   total;
      longint unsigned   dx;
      longint unsigned   dy;
      longint unsigned   e;
      longint unsigned   w;
      int                i;
      int                j;
      total = 0;
      for (j = 0; j < KW; j++) begin
         for (i = 0; i < KW; i++) begin
            dx = (i > RADIUS) ? longint'(i - RADIUS) : longint'(RADIUS - i);
            dy = (j > RADIUS) ? longint'(j - RADIUS) : longint'(RADIUS - j);
            e  = exp_q32(dx * dx + dy * dy, 8);
            g[j * KW + i] = udiv64((64'd1 << 62) + e / 2, e);
            total = total + g[j * KW + i];
         end
      end
      for (i = 0; i < TAPS; i++) begin
         w = udiv64(g[i] * 65536 + total / 2, total);
         tbl[i] = (w > 65535) ? 16'hFFFF : w[15:0];
      end
      return tbl;
   endfunction

   function automatic range_table_type build_range();
      range_table_type tbl;
      longint unsigned e;
      longint unsigned w;
      int              d;
      for (d = 0; d < 256; d++) begin
         e = exp_q32(longint'(d) * longint'(d), 20000);
         w = udiv64((64'd1 << 48) + e / 2, e);
         tbl[d] = (w > 65535) ? 16'hFFFF : w[15:0];
      end
      return tbl;
   endfunction

   localparam spatial_table_type SPATIAL_WEIGHTS = build_spatial();
   localparam range_table_type   RANGE_WEIGHTS   = build_range();

endpackage

`default_nettype wire

[rtl/bf7_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bf7_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              write_enable,
   input  wire logic [ADDR_W-1:0] write_address,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic              read_enable,
   input  wire logic [ADDR_W-1:0] read_address,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem[read_address];
      end
   end

endmodule

`default_nettype wire

[rtl/bf7_datapath.sv]
// Datapath of the bilateral filter: frame counters, line store, weighting pipeline,
// divider and result register. Uses bf7_pkg, bf7_ram and the assertion header.
`default_nettype none
`include "bilateral_filter_7x7_core_assert.svh"

module bf7_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_command,
   input  wire logic [bf7_pkg::PIXEL_W-1:0]         req_pixel_in,
   input  wire logic                                csr_write_enable,
   input  wire logic [bf7_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bf7_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic      [bf7_pkg::PIXEL_W-1:0]         rsp_pixel_out,
   output logic      [bf7_pkg::COL_W-1:0]           rsp_out_column,
   output logic      [bf7_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                     rsp_frame_last,
   input  wire bf7_pkg::cmd_type                    cmd_i,
   output bf7_pkg::status_type                      status_o
);

   localparam int AW = bf7_pkg::LS_ADDR_W;

   // configuration
   logic [bf7_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [bf7_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [bf7_pkg::WIDTH_REG_W-1:0]  w_eff;
   logic [bf7_pkg::HEIGHT_REG_W-1:0] h_eff;
   logic [bf7_pkg::LAG_W-1:0]        thr;

   // frame position
   logic [bf7_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [bf7_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [AW-1:0]             in_addr_ff, in_addr_in;
   logic [bf7_pkg::COL_W-1:0] emit_col_ff, emit_col_in;
   logic [bf7_pkg::ROW_W-1:0] emit_row_ff, emit_row_in;
   logic [AW-1:0]             ebase_ff, ebase_in;
   logic                      draining_ff, draining_in;
   logic [bf7_pkg::LAG_W-1:0] lag_ff, lag_in;

   logic                                 pix_take, emit_now, emit_last;
   logic [bf7_pkg::WIDTH_REG_W-1:0]      col_next, ecol_next;
   logic [bf7_pkg::HEIGHT_REG_W-1:0]     row_next, erow_next;
   logic [AW:0]                          addr_inc, ebase_sum;

   // current job
   logic [bf7_pkg::COL_W-1:0] job_col_ff;
   logic [bf7_pkg::ROW_W-1:0] job_row_ff;
   logic [AW-1:0]             job_base_ff;
   logic                      job_last_ff;

   // window address
   logic signed [13:0]        vy, dy;
   logic signed [11:0]        vx;
   logic [bf7_pkg::ROW_W-1:0] iy;
   logic [bf7_pkg::COL_W-1:0] ix;
   logic signed [3:0]         dyc;
   logic signed [15:0]        row_off, addr_sum, addr_fix;
   logic [AW-1:0]             rd_addr;
   logic [bf7_pkg::PIXEL_W-1:0] rd_data;

   // weighting pipeline
   logic [bf7_pkg::PIXEL_W-1:0]   ip_ff;
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [bf7_pkg::TAP_W-1:0]     s1_i_ff, s1_j_ff;
   logic [bf7_pkg::TAP_IDX_W-1:0] ws_idx;
   logic [bf7_pkg::PIXEL_W-1:0]   diff;
   logic [bf7_pkg::WEIGHT_W-1:0]  ws_ff, wr_ff;
   logic [bf7_pkg::PIXEL_W-1:0]   iq2_ff, iq3_ff;
   logic [bf7_pkg::WT_W-1:0]      wt_ff;
   logic [bf7_pkg::WT_W+bf7_pkg::PIXEL_W-1:0] prod;
   logic [bf7_pkg::DEN_W-1:0]     den_ff;
   logic [bf7_pkg::NUM_W-1:0]     num_ff;

   // divider and result
   logic [bf7_pkg::NUM_W-1:0]   rem_ff;
   logic [bf7_pkg::QUO_W-1:0]   quo_ff;
   logic [bf7_pkg::NUM_W:0]     trial;
   logic                        fits;
   logic [bf7_pkg::PIXEL_W-1:0] pix_res;
   logic                        rsp_valid_ff;

   // ---------------- configuration and position counters ----------------
   always_comb begin
      if (width_ff == '0) begin
         w_eff = bf7_pkg::WIDTH_REG_W'(1);
      end else if (width_ff > bf7_pkg::WIDTH_REG_W'(bf7_pkg::MAX_WIDTH)) begin
         w_eff = bf7_pkg::WIDTH_REG_W'(bf7_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = bf7_pkg::HEIGHT_REG_W'(1);
      end else if (height_ff > bf7_pkg::HEIGHT_REG_W'(bf7_pkg::MAX_HEIGHT)) begin
         h_eff = bf7_pkg::HEIGHT_REG_W'(bf7_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      thr = bf7_pkg::LAG_W'(bf7_pkg::RADIUS * int'(w_eff) + bf7_pkg::RADIUS);
   end

   assign pix_take  = (req_command == bf7_pkg::CMD_PIXEL) && !draining_ff;
   assign emit_now  = pix_take ? (lag_ff >= thr)
                               : ((req_command == bf7_pkg::CMD_DRAIN) && draining_ff);
   assign col_next  = {1'b0, in_col_ff} + 1'b1;
   assign row_next  = {1'b0, in_row_ff} + 1'b1;
   assign addr_inc  = {1'b0, in_addr_ff} + 1'b1;
   assign ecol_next = {1'b0, emit_col_ff} + 1'b1;
   assign erow_next = {1'b0, emit_row_ff} + 1'b1;
   assign ebase_sum = {1'b0, ebase_ff} + (AW+1)'(w_eff);
   assign emit_last = ({1'b0, emit_row_ff} == h_eff - 1'b1)
                   && ({1'b0, emit_col_ff} == w_eff - 1'b1);

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_addr_in  = in_addr_ff;
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      ebase_in    = ebase_ff;
      draining_in = draining_ff;
      lag_in      = lag_ff;

      if (cmd_i.accept && pix_take) begin
         if (col_next >= w_eff) begin
            in_col_in = '0;
            if (row_next >= h_eff) begin
               in_row_in   = '0;
               draining_in = 1'b1;
            end else begin
               in_row_in = row_next[bf7_pkg::ROW_W-1:0];
            end
         end else begin
            in_col_in = col_next[bf7_pkg::COL_W-1:0];
         end
         // linear index of the next pixel, wrapped to the store depth and zeroed at frame end
         if (col_next >= w_eff && row_next >= h_eff) begin
            in_addr_in = '0;
         end else if (addr_inc >= (AW+1)'(bf7_pkg::LS_DEPTH)) begin
            in_addr_in = '0;
         end else begin
            in_addr_in = addr_inc[AW-1:0];
         end
         if (!emit_now) begin
            lag_in = lag_ff + 1'b1;
         end
      end

      if (cmd_i.accept && emit_now) begin
         if (emit_last) begin
            emit_col_in = '0;
            emit_row_in = '0;
            ebase_in    = '0;
            draining_in = 1'b0;
            lag_in      = '0;
         end else if (ecol_next >= w_eff) begin
            emit_col_in = '0;
            emit_row_in = erow_next[bf7_pkg::ROW_W-1:0];
            if (ebase_sum >= (AW+1)'(bf7_pkg::LS_DEPTH)) begin
               ebase_in = AW'(ebase_sum - (AW+1)'(bf7_pkg::LS_DEPTH));
            end else begin
               ebase_in = ebase_sum[AW-1:0];
            end
         end else begin
            emit_col_in = ecol_next[bf7_pkg::COL_W-1:0];
         end
      end

      // a register write restarts the frame
      if (csr_write_enable) begin
         case (csr_index)
            bf7_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_write_data[bf7_pkg::WIDTH_REG_W-1:0];
            end
            bf7_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_write_data;
            end
            default: begin
            end
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         in_addr_in  = '0;
         emit_col_in = '0;
         emit_row_in = '0;
         ebase_in    = '0;
         draining_in = 1'b0;
         lag_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bf7_pkg::WIDTH_REG_W'(1024);
         height_ff   <= bf7_pkg::HEIGHT_REG_W'(1024);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_addr_ff  <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
         ebase_ff    <= '0;
         draining_ff <= 1'b0;
         lag_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_addr_ff  <= in_addr_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
         ebase_ff    <= ebase_in;
         draining_ff <= draining_in;
         lag_ff      <= lag_in;
      end
   end

   // latch the pixel to be filtered
   always_ff @(posedge clock) begin
      if (cmd_i.accept && emit_now) begin
         job_col_ff  <= emit_col_ff;
         job_row_ff  <= emit_row_ff;
         job_base_ff <= ebase_ff;
         job_last_ff <= emit_last;
      end
   end

   // ---------------- window address with edge clamping ----------------
   always_comb begin
      vy = $signed({2'b00, job_row_ff}) + $signed({11'b0, cmd_i.tap_j})
         - $signed(14'(bf7_pkg::RADIUS));
      if (vy < 0) begin
         iy = '0;
      end else if (vy >= $signed({1'b0, h_eff})) begin
         iy = bf7_pkg::ROW_W'(h_eff - 1'b1);
      end else begin
         iy = vy[bf7_pkg::ROW_W-1:0];
      end
      vx = $signed({2'b00, job_col_ff}) + $signed({9'b0, cmd_i.tap_i})
         - $signed(12'(bf7_pkg::RADIUS));
      if (vx < 0) begin
         ix = '0;
      end else if (vx >= $signed({1'b0, w_eff})) begin
         ix = bf7_pkg::COL_W'(w_eff - 1'b1);
      end else begin
         ix = vx[bf7_pkg::COL_W-1:0];
      end
      dy       = $signed({2'b00, iy}) - $signed({2'b00, job_row_ff});
      dyc      = dy[3:0];
      row_off  = $signed({{12{dyc[3]}}, dyc}) * $signed({5'b0, w_eff});
      addr_sum = $signed({3'b0, job_base_ff}) + row_off + $signed({6'b0, ix});
      if (addr_sum < 0) begin
         addr_fix = addr_sum + 16'(bf7_pkg::LS_DEPTH);
      end else if (addr_sum >= $signed(16'(bf7_pkg::LS_DEPTH))) begin
         addr_fix = addr_sum - 16'(bf7_pkg::LS_DEPTH);
      end else begin
         addr_fix = addr_sum;
      end
      rd_addr = addr_fix[AW-1:0];
   end

   bf7_ram #(
      .WIDTH (bf7_pkg::PIXEL_W),
      .DEPTH (bf7_pkg::LS_DEPTH)
   ) u_line_store (
      .clock         (clock),
      .write_enable  (cmd_i.accept && pix_take),
      .write_address (in_addr_ff),
      .write_data    (req_pixel_in),
      .read_enable   (cmd_i.read),
      .read_address  (rd_addr),
      .read_data     (rd_data)
   );

   // ---------------- weighting pipeline ----------------
   assign diff   = (ip_ff > rd_data) ? (ip_ff - rd_data) : (rd_data - ip_ff);
   assign ws_idx = bf7_pkg::TAP_IDX_W'(s1_j_ff) * bf7_pkg::TAP_IDX_W'(bf7_pkg::KW)
                 + bf7_pkg::TAP_IDX_W'(s1_i_ff);
   assign prod   = {8'b0, wt_ff} * {32'b0, iq3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_i.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_i_ff <= cmd_i.tap_i;
      s1_j_ff <= cmd_i.tap_j;
      if (cmd_i.latch_center) begin
         ip_ff <= rd_data;
      end
      ws_ff  <= bf7_pkg::SPATIAL_WEIGHTS[ws_idx];
      wr_ff  <= bf7_pkg::RANGE_WEIGHTS[diff];
      iq2_ff <= rd_data;
      wt_ff  <= ws_ff * wr_ff;
      iq3_ff <= iq2_ff;
      if (cmd_i.start) begin
         den_ff <= '0;
         num_ff <= '0;
      end else if (s3_valid_ff) begin
         den_ff <= den_ff + bf7_pkg::DEN_W'(wt_ff);
         num_ff <= num_ff + bf7_pkg::NUM_W'(prod);
      end
   end

   // ---------------- restoring divider, one quotient bit per step ----------------
   assign trial = {{(bf7_pkg::NUM_W + 1 - bf7_pkg::DEN_W){1'b0}}, den_ff} << cmd_i.div_shift;
   assign fits  = {1'b0, rem_ff} >= trial;

   always_ff @(posedge clock) begin
      if (cmd_i.div_load) begin
         rem_ff <= num_ff;
         quo_ff <= '0;
      end else if (cmd_i.div_step) begin
         if (fits) begin
            rem_ff <= rem_ff - trial[bf7_pkg::NUM_W-1:0];
         end
         quo_ff <= {quo_ff[bf7_pkg::QUO_W-2:0], fits};
      end
   end

   always_comb begin
      if (den_ff == '0) begin
         pix_res = ip_ff;
      end else if (quo_ff[bf7_pkg::QUO_W-1]) begin
         pix_res = '1;
      end else begin
         pix_res = quo_ff[bf7_pkg::PIXEL_W-1:0];
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.rsp_load) begin
         rsp_pixel_out  <= pix_res;
         rsp_out_column <= job_col_ff;
         rsp_out_row    <= job_row_ff;
         rsp_frame_last <= job_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign status_o.emit_now  = emit_now;
   assign status_o.pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign status_o.rsp_free  = !rsp_valid_ff || rsp_ready;

   `BF7_ASSERT_ALWAYS(a_ebase_range, clock, reset, ebase_ff < AW'(bf7_pkg::LS_DEPTH))
   `BF7_ASSERT_ALWAYS(a_in_addr_range, clock, reset, in_addr_ff < AW'(bf7_pkg::LS_DEPTH))
   `BF7_ASSERT_ALWAYS(a_lag_bound, clock, reset, lag_ff <= thr)
   `BF7_ASSERT_NEXT(a_last_rewinds, clock, reset, cmd_i.accept && emit_now && emit_last, !draining_ff && emit_col_ff == '0 && emit_row_ff == '0)

endmodule

`default_nettype wire

[rtl/bf7_control.sv]
// Sequencer of the bilateral filter: handshake, tap walk, divider steps.
// Uses bf7_pkg; drives bf7_datapath through the command struct.
`default_nettype none

module bf7_control (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire bf7_pkg::status_type status_i,
   output bf7_pkg::cmd_type         cmd_o
);

   localparam logic [bf7_pkg::TAP_W-1:0] LAST_TAP   = bf7_pkg::TAP_W'(bf7_pkg::KW - 1);
   localparam logic [bf7_pkg::TAP_W-1:0] CENTER_TAP = bf7_pkg::TAP_W'(bf7_pkg::RADIUS);

   bf7_pkg::state_type           state_ff, state_in;
   logic [bf7_pkg::TAP_W-1:0]    tap_i_ff, tap_i_in;
   logic [bf7_pkg::TAP_W-1:0]    tap_j_ff, tap_j_in;
   logic [bf7_pkg::SHIFT_W-1:0]  shift_ff, shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bf7_pkg::ST_IDLE;
         tap_i_ff <= '0;
         tap_j_ff <= '0;
         shift_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_i_ff <= tap_i_in;
         tap_j_ff <= tap_j_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      tap_i_in        = tap_i_ff;
      tap_j_in        = tap_j_ff;
      shift_in        = shift_ff;
      req_ready       = 1'b0;
      cmd_o           = '0;
      cmd_o.tap_i     = tap_i_ff;
      cmd_o.tap_j     = tap_j_ff;
      cmd_o.div_shift = shift_ff;

      case (state_ff)
         bf7_pkg::ST_IDLE: begin
            // hold off words while reset is applied
            req_ready    = !reset;
            cmd_o.accept = req_valid && !reset;
            if (cmd_o.accept && status_i.emit_now) begin
               state_in = bf7_pkg::ST_CENTER;
            end
         end
         bf7_pkg::ST_CENTER: begin
            // fetch the center sample, clear the sums
            cmd_o.start = 1'b1;
            cmd_o.read  = 1'b1;
            cmd_o.tap_i = CENTER_TAP;
            cmd_o.tap_j = CENTER_TAP;
            tap_i_in    = '0;
            tap_j_in    = '0;
            state_in    = bf7_pkg::ST_TAPS;
         end
         bf7_pkg::ST_TAPS: begin
            cmd_o.read         = 1'b1;
            cmd_o.issue        = 1'b1;
            cmd_o.latch_center = (tap_i_ff == '0) && (tap_j_ff == '0);
            if (tap_i_ff == LAST_TAP) begin
               tap_i_in = '0;
               if (tap_j_ff == LAST_TAP) begin
                  state_in = bf7_pkg::ST_FLUSH;
               end else begin
                  tap_j_in = tap_j_ff + 1'b1;
               end
            end else begin
               tap_i_in = tap_i_ff + 1'b1;
            end
         end
         bf7_pkg::ST_FLUSH: begin
            if (!status_i.pipe_busy) begin
               cmd_o.div_load = 1'b1;
               shift_in       = bf7_pkg::SHIFT_W'(bf7_pkg::QUO_W - 1);
               state_in       = bf7_pkg::ST_DIVIDE;
            end
         end
         bf7_pkg::ST_DIVIDE: begin
            cmd_o.div_step = 1'b1;
            if (shift_ff == '0) begin
               state_in = bf7_pkg::ST_DONE;
            end else begin
               shift_in = shift_ff - 1'b1;
            end
         end
         bf7_pkg::ST_DONE: begin
            if (status_i.rsp_free) begin
               cmd_o.rsp_load = 1'b1;
               state_in       = bf7_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bf7_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/bilateral_filter_7x7_core.sv]
// Top level of the 7x7 bilateral filter core: sequencer plus datapath.
// Uses bf7_pkg, bf7_control and bf7_datapath (which holds the line store RAM).
//
//   port group | direction | handshake            | payload
//   req_*      | in        | req_valid/req_ready  | command, pixel_in
//   rsp_*      | out       | rsp_valid/rsp_ready  | pixel_out, out_column, out_row, frame_last
//   csr_*      | in        | csr_write_enable     | csr_index, csr_write_data
//
// A word that yields no output leaves the sequencer idle: req_ready is high again the next cycle.
// A word that yields an output drops req_ready while the sequencer works: one center fetch,
// the 49 window taps read one per cycle from the single read port of the line store, a wait
// while the 3-stage weight pipeline drains, the restoring divider steps (one quotient bit
// each) and the load of the output register. The next word is taken while a result waits;
// a new result stalls only while that register is still full. req_ready is low during reset.
// Reset is synchronous, active high; the line store needs no clearing pass.
`default_nettype none

module bilateral_filter_7x7_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_command,
   input  wire logic [bf7_pkg::PIXEL_W-1:0]         req_pixel_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [bf7_pkg::PIXEL_W-1:0]         rsp_pixel_out,
   output logic      [bf7_pkg::COL_W-1:0]           rsp_out_column,
   output logic      [bf7_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                     rsp_frame_last,
   input  wire logic                                csr_write_enable,
   input  wire logic [bf7_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bf7_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // command and status between the sequencer and the datapath
   bf7_pkg::cmd_type    cmd;
   bf7_pkg::status_type status;

   // sequencer: owns req_ready, walks the window and the divider
   bf7_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   // datapath: counters, line store, weighting, divide, output register
   bf7_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_pixel_in     (req_pixel_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_row      (rsp_out_row),
      .rsp_frame_last   (rsp_frame_last),
      .cmd_i            (cmd),
      .status_o         (status)
   );

endmodule

`default_nettype wire

[tb/bilateral_filter_7x7_core_test.sv]
// Self-checking testbench for the 7x7 bilateral filter core: directed frames,
// extreme sizes, backpressure and random frames. Depends on bf7_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module bilateral_filter_7x7_core_test;

   localparam int STORE_DEPTH = 7 * 1024;
   localparam int SETTLE      = 100;   // covers the filter latency

   typedef struct packed {
      logic [7:0]  pixel;
      logic [9:0]  column;
      logic [11:0] row;
      logic        last;
   } filtered_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_command = bf7_pkg::CMD_PIXEL;
   logic [bf7_pkg::PIXEL_W-1:0]        req_pixel_in = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [bf7_pkg::PIXEL_W-1:0]        rsp_pixel_out;
   logic [bf7_pkg::COL_W-1:0]          rsp_out_column;
   logic [bf7_pkg::ROW_W-1:0]          rsp_out_row;
   logic                               rsp_frame_last;
   logic                               csr_write_enable = 1'b0;
   logic [bf7_pkg::CSR_INDEX_W-1:0]    csr_index = bf7_pkg::CSR_IMAGE_WIDTH;
   logic [bf7_pkg::CSR_DATA_W-1:0]     csr_write_data = '0;

   // filter state as the block should hold it
   logic [7:0]      filt_store [STORE_DEPTH];
   logic [15:0]     gauss_wt [49];
   logic [15:0]     range_wt [256];
   int unsigned     width_reg, height_reg;
   int unsigned     in_col, in_row, em_col, em_row;
   bit              draining;
   filtered_type    pending_q [$];

   int   errors = 0;
   int   words_sent = 0;
   int   results_seen = 0;
   bit   no_idle = 1'b0;
   int   hold_left = 0;

   always #5 clock = ~clock;

   bilateral_filter_7x7_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pixel_out(rsp_pixel_out), .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row), .rsp_frame_last(rsp_frame_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // exp(num/den) in Q32, truncated Taylor sum
   function automatic longint unsigned taylor_exp(longint unsigned num, longint unsigned den);
      longint unsigned acc, term;
      acc  = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k < 80; k++) begin
         term = term * num / (den * k);
         if (term == 0) break;
         acc += term;
      end
      return acc;
   endfunction

   task automatic build_weights();
      longint unsigned g [49];
      longint unsigned total, e, w, dx, dy;
      total = 0;
      for (int j = 0; j < 7; j++) begin
         for (int i = 0; i < 7; i++) begin
            dx = (i > 3) ? i - 3 : 3 - i;
            dy = (j > 3) ? j - 3 : 3 - j;
            e  = taylor_exp(dx * dx + dy * dy, 8);
            g[j * 7 + i] = ((64'd1 << 62) + e / 2) / e;
            total += g[j * 7 + i];
         end
      end
      for (int i = 0; i < 49; i++) begin
         w = (g[i] * 65536 + total / 2) / total;
         gauss_wt[i] = (w > 65535) ? 16'hFFFF : w[15:0];
      end
      for (int d = 0; d < 256; d++) begin
         e = taylor_exp(longint'(d) * longint'(d), 20000);
         w = ((64'd1 << 48) + e / 2) / e;
         range_wt[d] = (w > 65535) ? 16'hFFFF : w[15:0];
      end
   endtask

   function automatic int unsigned frame_width();
      if (width_reg == 0) return 1;
      return (width_reg > 1024) ? 1024 : width_reg;
   endfunction

   function automatic int unsigned frame_height();
      if (height_reg == 0) return 1;
      return (height_reg > 4096) ? 4096 : height_reg;
   endfunction

   function automatic logic [7:0] smooth_pixel(int ex, int ey, int w, int h);
      longint unsigned num, den, wt;
      int ip, iq, ix, iy, d;
      num = 0;
      den = 0;
      ip  = filt_store[(ey * w + ex) % STORE_DEPTH];
      for (int j = 0; j < 7; j++) begin
         for (int i = 0; i < 7; i++) begin
            ix = ex + i - 3;
            iy = ey + j - 3;
            ix = (ix < 0) ? 0 : (ix >= w) ? w - 1 : ix;
            iy = (iy < 0) ? 0 : (iy >= h) ? h - 1 : iy;
            iq = filt_store[(iy * w + ix) % STORE_DEPTH];
            d  = (ip > iq) ? ip - iq : iq - ip;
            wt = longint'(gauss_wt[j * 7 + i]) * range_wt[d];
            den += wt;
            num += wt * iq;
         end
      end
      if (den == 0) return ip[7:0];
      num = num / den;
      return (num > 255) ? 8'hFF : num[7:0];
   endfunction

   // queue the next output in raster order and advance the emit position
   task automatic emit_next(int unsigned w, int unsigned h);
      filtered_type r;
      r.last   = (em_row == h - 1) && (em_col == w - 1);
      r.pixel  = smooth_pixel(em_col, em_row, w, h);
      r.column = em_col[9:0];
      r.row    = em_row[11:0];
      pending_q.push_back(r);
      if (r.last) begin
         em_col   = 0;
         em_row   = 0;
         draining = 1'b0;
      end else if (++em_col >= w) begin
         em_col = 0;
         em_row++;
      end
   endtask

   task automatic filter_step(logic cmd, logic [7:0] pix);
      int unsigned w, h, p, e;
      w = frame_width();
      h = frame_height();
      if (cmd == bf7_pkg::CMD_PIXEL) begin
         if (draining) return;
         p = in_row * w + in_col;
         e = em_row * w + em_col;
         filt_store[p % STORE_DEPTH] = pix;
         if (++in_col >= w) begin
            in_col = 0;
            if (++in_row >= h) begin
               in_row   = 0;
               draining = 1'b1;
            end
         end
         if (p >= e && p - e >= 3 * w + 3) emit_next(w, h);
      end else if (draining) begin
         emit_next(w, h);
      end
   endtask

   // one word: random gap, then hold valid until the block takes it
   task automatic send_word(logic cmd, logic [7:0] pix);
      while (!no_idle && $urandom_range(99) < 14) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      filter_step(cmd, pix);
   endtask

   // drop valid, let all results out, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [bf7_pkg::CSR_INDEX_W-1:0] idx, int unsigned value);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[bf7_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == bf7_pkg::CSR_IMAGE_WIDTH) width_reg = value & 11'h7FF;
      else height_reg = value & 13'h1FFF;
      in_col   = 0;
      in_row   = 0;
      em_col   = 0;
      em_row   = 0;
      draining = 1'b0;
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      write_csr(bf7_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(bf7_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   // send the pixels left in the frame, then drain until frame_last
   task automatic finish_frame(int pattern);
      int unsigned base;
      base = $urandom_range(255);
      do begin
         case (pattern)
            0:       send_word(bf7_pkg::CMD_PIXEL, 8'($urandom_range(255)));
            1:       send_word(bf7_pkg::CMD_PIXEL, 8'(base + $urandom_range(40) - 20));
            default: send_word(bf7_pkg::CMD_PIXEL, ($urandom_range(1)) ? 8'hFF : 8'h00);
         endcase
      end while (!draining);
      while (draining) send_word(bf7_pkg::CMD_DRAIN, 8'($urandom_range(255)));
   endtask

   // ignored words (drain with nothing pending, pixels while draining), then small frames
   task test_directed();
      set_frame(3, 2);
      send_word(bf7_pkg::CMD_DRAIN, 8'hA5);
      send_word(bf7_pkg::CMD_PIXEL, 8'h00);
      send_word(bf7_pkg::CMD_PIXEL, 8'hFF);
      send_word(bf7_pkg::CMD_PIXEL, 8'h00);
      send_word(bf7_pkg::CMD_PIXEL, 8'hFF);
      send_word(bf7_pkg::CMD_PIXEL, 8'h55);
      send_word(bf7_pkg::CMD_PIXEL, 8'hAA);
      send_word(bf7_pkg::CMD_PIXEL, 8'h12);   // ignored: frame is draining
      while (draining) send_word(bf7_pkg::CMD_DRAIN, 8'h00);
      send_word(bf7_pkg::CMD_DRAIN, 8'hFF);
      // single-pixel frame through zero width and zero height
      set_frame(0, 0);
      send_word(bf7_pkg::CMD_PIXEL, 8'h7F);
      send_word(bf7_pkg::CMD_DRAIN, 8'h00);
      // frame taller than the lag: outputs during input, then drains
      set_frame(7, 5);
      finish_frame(2);
   endtask

   // oversized registers clamp; those frames are cut short by the next write
   task test_size_extremes();
      set_frame(2047, 1);    // width clamps to its maximum
      repeat (40) send_word(bf7_pkg::CMD_PIXEL, 8'($urandom_range(255)));
      set_frame(1, 8191);    // height clamps to its maximum
      repeat (40) send_word(bf7_pkg::CMD_PIXEL, 8'($urandom_range(255)));
      set_frame(60, 1);      // wide single row, every output from drains
      finish_frame(1);
      set_frame(1, 12);      // single column
      finish_frame(0);
   endtask

   // hold the result side off so the output register fills and input stalls
   task test_backpressure();
      set_frame(8, 8);
      hold_left = 400;
      finish_frame(0);
   endtask

   task test_random();
      int frames;
      frames = 0;
      while (words_sent < 880) begin
         no_idle = (frames < 4);
         if (frames == 0 || $urandom_range(3) == 0) begin
            if ($urandom_range(9) == 0)
               set_frame($urandom_range(20, 32), $urandom_range(1, 4));
            else
               set_frame($urandom_range(1, 12), $urandom_range(1, 9));
         end
         if ($urandom_range(7) == 0)
            send_word(bf7_pkg::CMD_DRAIN, 8'($urandom_range(255)));
         if ($urandom_range(9) == 0) begin
            // abandon the frame part way; a register write restarts it
            repeat ($urandom_range(1, 10))
               send_word(bf7_pkg::CMD_PIXEL, 8'($urandom_range(255)));
            write_csr(bf7_pkg::CSR_IMAGE_WIDTH, width_reg);
         end
         finish_frame($urandom_range(2));
         if ($urandom_range(4) == 0)
            send_word(bf7_pkg::CMD_PIXEL, 8'($urandom_range(255)));
         frames++;
      end
      no_idle = 1'b0;
   endtask

   // result side: random stalls, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected output pixel %0d at (%0d,%0d)", $time,
                     rsp_pixel_out, rsp_out_column, rsp_out_row);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_out_column !== want.column ||
                rsp_out_row !== want.row || rsp_frame_last !== want.last) begin
               $display("%0t: expected pix %0d col %0d row %0d last %0d, got %0d %0d %0d %0d",
                        $time, want.pixel, want.column, want.row, want.last,
                        rsp_pixel_out, rsp_out_column, rsp_out_row, rsp_frame_last);
               errors++;
            end
         end
      end
   end

   initial begin
      #40ms;
      $display("bilateral_filter_7x7_core_test: errors");
      $finish;
   end

   initial begin
      build_weights();
      for (int i = 0; i < STORE_DEPTH; i++) filt_store[i] = '0;
      width_reg  = 1024;
      height_reg = 1024;
      in_col     = 0;
      in_row     = 0;
      em_col     = 0;
      em_row     = 0;
      draining   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_size_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      $display("Covered %0d words and %0d filtered pixels over directed, size-extreme,",
               words_sent, results_seen);
      $display("backpressure and random frames.");
      if (errors == 0) begin
         $display("bilateral_filter_7x7_core_test: clean");
      end else begin
         $display("bilateral_filter_7x7_core_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
